// ===== src/tt_pkg.sv =====
`timescale 1ns / 1ps

package tt_pkg;

    // Bucket index width; the table holds 2**INDEX_BITS buckets of two slots.
    localparam int INDEX_BITS  = 12;
    localparam int BUCKETS     = 1 << INDEX_BITS;
    localparam int KEY_W       = 64;

    // Command queue between the front and the back end.
    localparam int QUEUE_DEPTH = 2;
    localparam int Q_PTR_W     = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int Q_CNT_W     = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic {
        OP_LOOKUP = 1'b0,
        OP_STORE  = 1'b1
    } t_op;

    typedef enum logic [1:0] {
        KIND_EMPTY = 2'd0,
        KIND_EXACT = 2'd1,
        KIND_ALPHA = 2'd2,
        KIND_BETA  = 2'd3
    } t_kind;

    typedef enum logic [2:0] {
        OUT_MISS   = 3'd0,
        OUT_HIT    = 3'd1,
        OUT_EXACT  = 3'd2,
        OUT_CUTOFF = 3'd3,
        OUT_WINDOW = 3'd4,
        OUT_STORED = 3'd5
    } t_outcome;

    typedef enum logic [1:0] {
        ST_CLEAR = 2'd0,
        ST_IDLE  = 2'd1,
        ST_EVAL  = 2'd2
    } t_back_state;

    // Stored payload of one slot, score in the low bits.
    typedef struct packed {
        logic [15:0]        prio;
        logic [7:0]         depth;
        t_kind              kind;
        logic signed [8:0]  move;
        logic signed [15:0] score;
    } t_payload;

    typedef struct packed {
        logic [KEY_W-1:0] key;
        t_payload         pay;
    } t_slot;

    localparam int SLOT_W = $bits(t_slot);

    // One classified command as it waits in the queue.
    typedef struct packed {
        t_op                    op;
        logic [INDEX_BITS-1:0]  idx;
        logic [KEY_W-1:0]       key;
        logic [7:0]             depth;
        logic signed [15:0]     score;
        logic [15:0]            prio;
        t_kind                  kind;
        logic signed [8:0]      move;
        logic signed [15:0]     alpha;
        logic signed [15:0]     beta;
    } t_item;

    // Status from the back end to the front end.
    typedef struct packed {
        logic pop;
        logic clearing;
    } t_back_status;

endpackage

// ===== src/tt_ram.sv =====
`timescale 1ns / 1ps

module tt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== src/tt_front.sv =====
`timescale 1ns / 1ps

module tt_front (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    start,
    output logic                    busy,
    input  logic                    i_opcode,
    input  logic [63:0]             i_position_key,
    input  logic [7:0]              i_search_depth,
    input  logic signed [15:0]      i_score,
    input  logic [15:0]             i_keep_priority,
    input  logic [1:0]              i_bound_kind,
    input  logic signed [8:0]       i_move_to_store,
    input  logic signed [15:0]      i_alpha_bound,
    input  logic signed [15:0]      i_beta_bound,
    input  tt_pkg::t_back_status    i_status,
    output tt_pkg::t_item           o_head,
    output logic                    o_head_valid
);

    tt_pkg::t_item                 r_q [tt_pkg::QUEUE_DEPTH];
    logic [tt_pkg::Q_PTR_W-1:0]    r_wptr, n_wptr;
    logic [tt_pkg::Q_PTR_W-1:0]    r_rptr, n_rptr;
    logic [tt_pkg::Q_CNT_W-1:0]    r_count, n_count;
    tt_pkg::t_item                 in_item;
    logic                          push;
    logic                          pop;
    logic                          full;

    // Classify the incoming command and pick its bucket.
    always_comb begin
        in_item.op    = tt_pkg::t_op'(i_opcode);
        in_item.idx   = i_position_key[tt_pkg::INDEX_BITS-1:0];
        in_item.key   = i_position_key;
        in_item.depth = i_search_depth;
        in_item.score = i_score;
        in_item.prio  = i_keep_priority;
        in_item.kind  = tt_pkg::t_kind'(i_bound_kind);
        in_item.move  = i_move_to_store;
        in_item.alpha = i_alpha_bound;
        in_item.beta  = i_beta_bound;
    end

    assign full         = (r_count == tt_pkg::Q_CNT_W'(tt_pkg::QUEUE_DEPTH));
    assign busy         = full || i_status.clearing;
    assign push         = start && !busy;
    assign o_head_valid = (r_count != '0);
    assign pop          = i_status.pop && o_head_valid;
    assign o_head       = r_q[r_rptr];

    always_comb begin
        n_wptr  = r_wptr;
        n_rptr  = r_rptr;
        n_count = r_count;
        if (push) begin
            n_wptr = (r_wptr == tt_pkg::Q_PTR_W'(tt_pkg::QUEUE_DEPTH - 1)) ? '0
                                                                           : r_wptr + 1'b1;
        end
        if (pop) begin
            n_rptr = (r_rptr == tt_pkg::Q_PTR_W'(tt_pkg::QUEUE_DEPTH - 1)) ? '0
                                                                           : r_rptr + 1'b1;
        end
        if (push && !pop) begin
            n_count = r_count + 1'b1;
        end else if (pop && !push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            r_wptr  <= n_wptr;
            r_rptr  <= n_rptr;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wptr] <= in_item;
        end
    end

endmodule

// ===== src/tt_back.sv =====
`timescale 1ns / 1ps

module tt_back (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  tt_pkg::t_item         i_head,
    input  logic                  i_head_valid,
    output tt_pkg::t_back_status  o_status,
    output logic                  o_done,
    output logic [2:0]            o_outcome,
    output logic signed [15:0]    o_found_score,
    output logic signed [8:0]     o_found_move,
    output logic signed [15:0]    o_window_low,
    output logic signed [15:0]    o_window_high
);

    localparam logic [tt_pkg::INDEX_BITS-1:0] LAST_IDX =
        tt_pkg::INDEX_BITS'(tt_pkg::BUCKETS - 1);

    tt_pkg::t_back_state              r_state, n_state;
    logic [tt_pkg::INDEX_BITS-1:0]    r_clr_idx;
    tt_pkg::t_item                    r_item;
    logic                             r_done;
    tt_pkg::t_outcome                 r_outcome, n_outcome;
    logic signed [15:0]               r_score, n_score;
    logic signed [8:0]                r_move, n_move;
    logic signed [15:0]               r_wlow, n_wlow;
    logic signed [15:0]               r_whigh, n_whigh;

    logic                             pop;
    logic                             we0, we1;
    logic [tt_pkg::INDEX_BITS-1:0]    waddr;
    tt_pkg::t_slot                    wslot;
    logic [tt_pkg::SLOT_W-1:0]        wdata0, wdata1;
    logic [tt_pkg::SLOT_W-1:0]        rdata0, rdata1;
    tt_pkg::t_slot                    slot0, slot1;
    tt_pkg::t_slot                    new_slot;
    logic                             to_slot1;

    logic                             hit0, hit1;
    tt_pkg::t_payload                 hp;
    logic signed [15:0]               val;
    logic signed [15:0]               alpha, beta;
    logic signed [16:0]               val_p1, val_m1, alpha17, beta17;
    logic signed [16:0]               hi17, lo17;

    // Both slots of a bucket sit at the same address of their own memory.
    tt_ram #(
        .WIDTH (tt_pkg::SLOT_W),
        .DEPTH (tt_pkg::BUCKETS)
    ) u_ram0 (
        .i_clk   (i_clk),
        .i_we    (we0),
        .i_waddr (waddr),
        .i_wdata (wdata0),
        .i_raddr (i_head.idx),
        .o_rdata (rdata0)
    );

    tt_ram #(
        .WIDTH (tt_pkg::SLOT_W),
        .DEPTH (tt_pkg::BUCKETS)
    ) u_ram1 (
        .i_clk   (i_clk),
        .i_we    (we1),
        .i_waddr (waddr),
        .i_wdata (wdata1),
        .i_raddr (i_head.idx),
        .o_rdata (rdata1)
    );

    assign slot0 = tt_pkg::t_slot'(rdata0);
    assign slot1 = tt_pkg::t_slot'(rdata1);

    // A store lands in slot 1 only when slot 0 is occupied and outranks it.
    assign to_slot1 = (slot0.pay.kind != tt_pkg::KIND_EMPTY) &&
                      (slot0.pay.prio > r_item.prio);

    always_comb begin
        new_slot.key        = r_item.key;
        new_slot.pay.prio   = r_item.prio;
        new_slot.pay.depth  = r_item.depth;
        new_slot.pay.kind   = r_item.kind;
        new_slot.pay.move   = r_item.move;
        new_slot.pay.score  = r_item.score;
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            tt_pkg::ST_CLEAR: begin
                if (r_clr_idx == LAST_IDX) begin
                    n_state = tt_pkg::ST_IDLE;
                end
            end
            tt_pkg::ST_IDLE: begin
                if (i_head_valid) begin
                    n_state = tt_pkg::ST_EVAL;
                end
            end
            tt_pkg::ST_EVAL: begin
                n_state = tt_pkg::ST_IDLE;
            end
            default: begin
                n_state = tt_pkg::ST_CLEAR;
            end
        endcase
    end

    always_comb begin
        pop   = 1'b0;
        we0   = 1'b0;
        we1   = 1'b0;
        waddr = r_item.idx;
        wslot = new_slot;
        case (r_state)
            tt_pkg::ST_CLEAR: begin
                we0   = 1'b1;
                we1   = 1'b1;
                waddr = r_clr_idx;
                wslot = '0;
            end
            tt_pkg::ST_IDLE: begin
                pop = i_head_valid;
            end
            tt_pkg::ST_EVAL: begin
                we0 = (r_item.op == tt_pkg::OP_STORE) && !to_slot1;
                we1 = (r_item.op == tt_pkg::OP_STORE) && to_slot1;
            end
            default: begin
                pop = 1'b0;
            end
        endcase
    end

    assign wdata0            = wslot;
    assign wdata1            = wslot;
    assign o_status.pop      = pop;
    assign o_status.clearing = (r_state == tt_pkg::ST_CLEAR);

    // Lookup evaluation on the bucket read in the previous cycle.
    assign hit0    = (slot0.key == r_item.key);
    assign hit1    = (slot1.key == r_item.key);
    assign hp      = hit0 ? slot0.pay : slot1.pay;
    assign val     = hp.score;
    assign alpha   = r_item.alpha;
    assign beta    = r_item.beta;
    assign alpha17 = 17'(alpha);
    assign beta17  = 17'(beta);
    assign val_p1  = 17'(val) + 17'sd1;
    assign val_m1  = 17'(val) - 17'sd1;
    assign hi17    = (beta17 < val_p1) ? beta17 : val_p1;
    assign lo17    = (alpha17 > val_m1) ? alpha17 : val_m1;

    always_comb begin
        n_outcome = tt_pkg::OUT_MISS;
        n_score   = '0;
        n_move    = -9'sd1;
        n_wlow    = '0;
        n_whigh   = '0;
        if (r_item.op == tt_pkg::OP_STORE) begin
            n_outcome = tt_pkg::OUT_STORED;
        end else if (hit0 || hit1) begin
            n_outcome = tt_pkg::OUT_HIT;
            n_move    = hp.move;
            if (hp.depth >= r_item.depth) begin
                case (hp.kind)
                    tt_pkg::KIND_EXACT: begin
                        n_outcome = tt_pkg::OUT_EXACT;
                        n_score   = val;
                    end
                    tt_pkg::KIND_ALPHA: begin
                        if (val <= alpha) begin
                            n_outcome = tt_pkg::OUT_CUTOFF;
                            n_score   = val;
                            n_move    = -9'sd1;
                        end else begin
                            n_outcome = tt_pkg::OUT_WINDOW;
                            n_wlow    = alpha;
                            n_whigh   = hi17[15:0];
                        end
                    end
                    tt_pkg::KIND_BETA: begin
                        if (val >= beta) begin
                            n_outcome = tt_pkg::OUT_CUTOFF;
                            n_score   = val;
                            n_move    = -9'sd1;
                        end else begin
                            n_outcome = tt_pkg::OUT_WINDOW;
                            n_wlow    = lo17[15:0];
                            n_whigh   = beta;
                        end
                    end
                    default: begin
                        n_outcome = tt_pkg::OUT_HIT;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= tt_pkg::ST_CLEAR;
            r_clr_idx <= '0;
            r_done    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= (r_state == tt_pkg::ST_EVAL);
            if (r_state == tt_pkg::ST_CLEAR) begin
                r_clr_idx <= r_clr_idx + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (pop) begin
            r_item <= i_head;
        end
        if (r_state == tt_pkg::ST_EVAL) begin
            r_outcome <= n_outcome;
            r_score   <= n_score;
            r_move    <= n_move;
            r_wlow    <= n_wlow;
            r_whigh   <= n_whigh;
        end
    end

    assign o_done        = r_done;
    assign o_outcome     = r_outcome;
    assign o_found_score = r_score;
    assign o_found_move  = r_move;
    assign o_window_low  = r_wlow;
    assign o_window_high = r_whigh;

    // A result strobe comes only after an evaluation cycle.
    a_done_after_eval: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> $past(r_state == tt_pkg::ST_EVAL))
        else $error("result strobe without an evaluation cycle");

    // A store writes exactly one slot of its bucket.
    a_store_one_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == tt_pkg::ST_EVAL && r_item.op == tt_pkg::OP_STORE)
            |-> $onehot({we0, we1}))
        else $error("store did not write exactly one slot");

    // The front end holds commands off while the table is being cleared.
    a_queue_empty_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == tt_pkg::ST_CLEAR) |-> !i_head_valid)
        else $error("command queued during clearing pass");

    // A stored outcome comes only from a store command.
    a_stored_from_store: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_done && r_outcome == tt_pkg::OUT_STORED)
            |-> $past(r_item.op == tt_pkg::OP_STORE))
        else $error("stored outcome for a lookup");

endmodule

// ===== src/two_way_transposition_table.sv =====
`timescale 1ns / 1ps

// Channel    Direction  Handshake                 Payload
// command    in         start high, busy low      i_opcode .. i_beta_bound
// result     out        o_done for one cycle      o_outcome .. o_window_high
//
// A command is queued at the edge where it transfers. The back end takes it
// from the queue when it is idle, reads the whole bucket from two memories
// with registered reads, decides in its evaluation state and registers the
// result onto the ports. It takes no new command until the last one has
// passed the bucket read and the slot write. After reset the table is swept
// clear, one bucket a cycle, over all 2**INDEX_BITS buckets (4096), with
// busy held high. Reset is synchronous and active low. The result side
// cannot stall; the two-entry command queue absorbs bursts, and busy rises
// only when it is full or while the table is being cleared.

module two_way_transposition_table (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic               i_opcode,
    input  logic [63:0]        i_position_key,
    input  logic [7:0]         i_search_depth,
    input  logic signed [15:0] i_score,
    input  logic [15:0]        i_keep_priority,
    input  logic [1:0]         i_bound_kind,
    input  logic signed [8:0]  i_move_to_store,
    input  logic signed [15:0] i_alpha_bound,
    input  logic signed [15:0] i_beta_bound,
    output logic               o_done,
    output logic [2:0]         o_outcome,
    output logic signed [15:0] o_found_score,
    output logic signed [8:0]  o_found_move,
    output logic signed [15:0] o_window_low,
    output logic signed [15:0] o_window_high
);

    tt_pkg::t_item        head;
    logic                 head_valid;
    tt_pkg::t_back_status status;

    // The front end classifies each command and queues it.
    tt_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .start           (start),
        .busy            (busy),
        .i_opcode        (i_opcode),
        .i_position_key  (i_position_key),
        .i_search_depth  (i_search_depth),
        .i_score         (i_score),
        .i_keep_priority (i_keep_priority),
        .i_bound_kind    (i_bound_kind),
        .i_move_to_store (i_move_to_store),
        .i_alpha_bound   (i_alpha_bound),
        .i_beta_bound    (i_beta_bound),
        .i_status        (status),
        .o_head          (head),
        .o_head_valid    (head_valid)
    );

    // The back end owns the table memories and produces the results.
    tt_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_head        (head),
        .i_head_valid  (head_valid),
        .o_status      (status),
        .o_done        (o_done),
        .o_outcome     (o_outcome),
        .o_found_score (o_found_score),
        .o_found_move  (o_found_move),
        .o_window_low  (o_window_low),
        .o_window_high (o_window_high)
    );

endmodule

// ===== tb/tb_two_way_transposition_table.sv =====
`timescale 1ns / 1ps

// Self-checking bench for the two-slot transposition table.
// A directed prologue walks the replacement rule and every lookup answer.
// A random body follows, built around a small pool of keys that crowd a few
// buckets, so stores, collisions, slot-1 placement and lookup hits stay frequent.
// Every transferred command updates a mirror of the table at the moment of
// transfer, and the answer it must produce is queued. The monitor pops that
// queue on each o_done strobe and compares the result field by field.

module tb_two_way_transposition_table;

    // One command as the bench drives it.
    typedef struct {
        tt_pkg::t_op        op;
        logic [63:0]        key;
        logic [7:0]         depth;
        logic signed [15:0] score;
        logic [15:0]        prio;
        tt_pkg::t_kind      kind;
        logic signed [8:0]  move;
        logic signed [15:0] alpha;
        logic signed [15:0] beta;
    } t_cmd;

    // One answer the table must give.
    typedef struct {
        tt_pkg::t_outcome   outcome;
        logic signed [15:0] score;
        logic signed [8:0]  move;
        logic signed [15:0] lo;
        logic signed [15:0] hi;
    } t_answer;

    localparam int SLOT_COUNT = tt_pkg::BUCKETS * 2;
    localparam int RANDOM_CMDS = 1200;
    localparam int POOL_SIZE = 24;

    logic               i_clk;
    logic               i_rst_n;
    logic               start;
    logic               busy;
    logic               i_opcode;
    logic [63:0]        i_position_key;
    logic [7:0]         i_search_depth;
    logic signed [15:0] i_score;
    logic [15:0]        i_keep_priority;
    logic [1:0]         i_bound_kind;
    logic signed [8:0]  i_move_to_store;
    logic signed [15:0] i_alpha_bound;
    logic signed [15:0] i_beta_bound;
    logic               o_done;
    logic [2:0]         o_outcome;
    logic signed [15:0] o_found_score;
    logic signed [8:0]  o_found_move;
    logic signed [15:0] o_window_low;
    logic signed [15:0] o_window_high;

    two_way_transposition_table u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .start           (start),
        .busy            (busy),
        .i_opcode        (i_opcode),
        .i_position_key  (i_position_key),
        .i_search_depth  (i_search_depth),
        .i_score         (i_score),
        .i_keep_priority (i_keep_priority),
        .i_bound_kind    (i_bound_kind),
        .i_move_to_store (i_move_to_store),
        .i_alpha_bound   (i_alpha_bound),
        .i_beta_bound    (i_beta_bound),
        .o_done          (o_done),
        .o_outcome       (o_outcome),
        .o_found_score   (o_found_score),
        .o_found_move    (o_found_move),
        .o_window_low    (o_window_low),
        .o_window_high   (o_window_high)
    );

    // Mirror of the table contents, cleared like the hardware after reset.
    logic [63:0]      mirror_keys [SLOT_COUNT];
    tt_pkg::t_payload mirror_pays [SLOT_COUNT];

    t_cmd    cmd_backlog[$];
    t_answer pending_answers[$];
    t_cmd    cur_cmd;

    int n_total;
    int n_sent;
    int n_stores;
    int n_results;
    int n_errors;
    int idle_left;
    bit burst_mode;
    int outcome_seen [6];

    logic [63:0] key_pool [POOL_SIZE];

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    task automatic report_mismatch(input string msg);
        $display("MISMATCH @%0t: %s", $time, msg);
        n_errors++;
    endtask

    // Computes the answer for one command and applies its effect on the
    // mirror, in the order the commands transfer.
    function automatic t_answer table_answer(input t_cmd c);
        int               base;
        int               slot;
        tt_pkg::t_payload p;
        int               val;
        int               lo;
        int               hi;
        int               a;
        int               b;
        t_answer          r;
        base = int'(c.key[tt_pkg::INDEX_BITS-1:0]) * 2;
        r.outcome = tt_pkg::OUT_STORED;
        r.score = '0;
        r.move = -9'sd1;
        r.lo = '0;
        r.hi = '0;
        if (c.op == tt_pkg::OP_STORE) begin
            // Slot 0 is kept only when it is occupied and outranks the new entry.
            slot = base;
            if (mirror_pays[base].kind != tt_pkg::KIND_EMPTY &&
                mirror_pays[base].prio > c.prio) begin
                slot = base + 1;
            end
            mirror_keys[slot] = c.key;
            p.prio = c.prio;
            p.depth = c.depth;
            p.kind = c.kind;
            p.move = c.move;
            p.score = c.score;
            mirror_pays[slot] = p;
            return r;
        end
        if (mirror_keys[base] == c.key) begin
            slot = base;
        end else if (mirror_keys[base + 1] == c.key) begin
            slot = base + 1;
        end else begin
            r.outcome = tt_pkg::OUT_MISS;
            return r;
        end
        p = mirror_pays[slot];
        val = int'($signed(p.score));
        a = int'(c.alpha);
        b = int'(c.beta);
        r.outcome = tt_pkg::OUT_HIT;
        r.move = p.move;
        if (p.depth >= c.depth) begin
            case (p.kind)
                tt_pkg::KIND_EXACT: begin
                    r.outcome = tt_pkg::OUT_EXACT;
                    r.score = p.score;
                end
                tt_pkg::KIND_ALPHA: begin
                    if (val <= a) begin
                        r.outcome = tt_pkg::OUT_CUTOFF;
                        r.score = p.score;
                        r.move = -9'sd1;
                    end else begin
                        // The upper end may reach one past the score range
                        // before the clamp to beta brings it back.
                        hi = (b < val + 1) ? b : val + 1;
                        r.outcome = tt_pkg::OUT_WINDOW;
                        r.lo = c.alpha;
                        r.hi = 16'(hi);
                    end
                end
                tt_pkg::KIND_BETA: begin
                    if (val >= b) begin
                        r.outcome = tt_pkg::OUT_CUTOFF;
                        r.score = p.score;
                        r.move = -9'sd1;
                    end else begin
                        lo = (a > val - 1) ? a : val - 1;
                        r.outcome = tt_pkg::OUT_WINDOW;
                        r.lo = 16'(lo);
                        r.hi = c.beta;
                    end
                end
                default: begin
                    // An empty kind is a plain hit at any depth.
                end
            endcase
        end
        return r;
    endfunction

    // Lookup-only fields of a store are filled with junk, and the other way
    // round, so that the table is seen to ignore them.
    function automatic t_cmd mk_store(input logic [63:0] key, input logic [7:0] depth,
                                      input int score, input int prio,
                                      input tt_pkg::t_kind kind, input int move);
        t_cmd c;
        c.op = tt_pkg::OP_STORE;
        c.key = key;
        c.depth = depth;
        c.score = 16'(score);
        c.prio = 16'(prio);
        c.kind = kind;
        c.move = 9'(move);
        c.alpha = 16'($urandom);
        c.beta = 16'($urandom);
        return c;
    endfunction

    function automatic t_cmd mk_lookup(input logic [63:0] key, input logic [7:0] depth,
                                       input int alpha, input int beta);
        t_cmd c;
        c.op = tt_pkg::OP_LOOKUP;
        c.key = key;
        c.depth = depth;
        c.score = 16'($urandom);
        c.prio = 16'($urandom);
        c.kind = tt_pkg::t_kind'($urandom_range(0, 3));
        c.move = 9'($urandom_range(0, 256) - 1);
        c.alpha = 16'(alpha);
        c.beta = 16'(beta);
        return c;
    endfunction

    // Mostly short gaps, a few long ones, and bursts with none at all.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (burst_mode) begin
            return 0;
        end
        if (r < 45) begin
            return 0;
        end
        if (r < 85) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(4, 24);
    endfunction

    function automatic int rand_score();
        if ($urandom_range(0, 1) == 1) begin
            return $urandom_range(0, 400) - 200;
        end
        return $urandom_range(0, 65535) - 32768;
    endfunction

    function automatic logic [7:0] rand_depth();
        if ($urandom_range(0, 9) < 8) begin
            return 8'($urandom_range(0, 12));
        end
        return 8'($urandom);
    endfunction

    // Random command body: pool keys keep the buckets busy, a fifth of the
    // commands use a fully random key, and key zero shows up now and then.
    function automatic t_cmd mk_random_cmd();
        logic [63:0] key;
        int          r;
        int          prio;
        r = $urandom_range(0, 99);
        if (r < 78) begin
            key = key_pool[$urandom_range(0, POOL_SIZE - 1)];
        end else if (r < 80) begin
            key = '0;
        end else begin
            key = {$urandom, $urandom};
        end
        if ($urandom_range(0, 1) == 1) begin
            prio = ($urandom_range(0, 1) == 1) ? $urandom_range(0, 7)
                                               : $urandom_range(0, 65535);
            return mk_store(key, rand_depth(), rand_score(), prio,
                            tt_pkg::t_kind'($urandom_range(0, 3)),
                            $urandom_range(0, 256) - 1);
        end
        return mk_lookup(key, rand_depth(), rand_score(), rand_score());
    endfunction

    // Driver: presents the backlog one command at a time. A command is held
    // while busy is high; after each transfer a gap is drawn before the next.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            start <= 1'b0;
        end else begin
            if (start && !busy) begin
                pending_answers.push_back(table_answer(cur_cmd));
                n_sent++;
                if (cur_cmd.op == tt_pkg::OP_STORE) begin
                    n_stores++;
                end
                if ($urandom_range(0, 99) < 3) begin
                    burst_mode = !burst_mode;
                end
            end
            if (start && busy) begin
                // The command has not transferred yet and stays on the ports.
            end else if (idle_left > 0) begin
                idle_left--;
                start <= 1'b0;
            end else if (cmd_backlog.size() > 0) begin
                cur_cmd = cmd_backlog.pop_front();
                i_opcode <= cur_cmd.op;
                i_position_key <= cur_cmd.key;
                i_search_depth <= cur_cmd.depth;
                i_score <= cur_cmd.score;
                i_keep_priority <= cur_cmd.prio;
                i_bound_kind <= cur_cmd.kind;
                i_move_to_store <= cur_cmd.move;
                i_alpha_bound <= cur_cmd.alpha;
                i_beta_bound <= cur_cmd.beta;
                start <= 1'b1;
                idle_left = pick_gap();
            end else begin
                start <= 1'b0;
            end
        end
    end

    // Monitor: every o_done strobe is one result transfer and must match the
    // oldest outstanding answer.
    always @(posedge i_clk) begin
        t_answer want;
        if (i_rst_n && o_done) begin
            if (pending_answers.size() == 0) begin
                report_mismatch($sformatf("unexpected result, outcome %0d", o_outcome));
            end else begin
                want = pending_answers.pop_front();
                n_results++;
                outcome_seen[want.outcome]++;
                if (o_outcome !== want.outcome) begin
                    report_mismatch($sformatf("outcome %0d, expected %s",
                                              o_outcome, want.outcome.name()));
                end
                if (o_found_score !== want.score) begin
                    report_mismatch($sformatf("found_score %0d, expected %0d",
                                              o_found_score, want.score));
                end
                if (o_found_move !== want.move) begin
                    report_mismatch($sformatf("found_move %0d, expected %0d",
                                              o_found_move, want.move));
                end
                if (o_window_low !== want.lo) begin
                    report_mismatch($sformatf("window_low %0d, expected %0d",
                                              o_window_low, want.lo));
                end
                if (o_window_high !== want.hi) begin
                    report_mismatch($sformatf("window_high %0d, expected %0d",
                                              o_window_high, want.hi));
                end
            end
        end
    end

    initial begin
        logic [63:0]                   k_a1;
        logic [63:0]                   k_a2;
        logic [63:0]                   k_a3;
        logic [63:0]                   k_top;
        logic [63:0]                   k_low;
        logic [63:0]                   k_mid;
        logic [63:0]                   k_hole;
        logic [63:0]                   k_ones;
        logic [tt_pkg::INDEX_BITS-1:0] pool_bucket [6];
        i_clk = 1'b0;
        i_rst_n = 1'b0;
        start = 1'b0;
        i_opcode = 1'b0;
        i_position_key = '0;
        i_search_depth = '0;
        i_score = '0;
        i_keep_priority = '0;
        i_bound_kind = '0;
        i_move_to_store = '0;
        i_alpha_bound = '0;
        i_beta_bound = '0;
        idle_left = 0;
        burst_mode = 1'b0;
        n_sent = 0;
        n_stores = 0;
        n_results = 0;
        n_errors = 0;
        for (int i = 0; i < 6; i++) begin
            outcome_seen[i] = 0;
        end
        for (int i = 0; i < SLOT_COUNT; i++) begin
            mirror_keys[i] = '0;
            mirror_pays[i] = '0;
        end

        k_a1 = 64'h1357_9bdf_0246_80a5;
        k_a2 = 64'hfedc_ba98_7654_30a5;
        k_a3 = 64'h8000_0000_0000_00a5;
        k_top = 64'h0f0f_f0f0_5555_a100;
        k_low = 64'h7fff_0000_aaaa_c200;
        k_mid = 64'h3c3c_c3c3_1234_5300;
        k_hole = 64'h0000_0001_0000_0400;
        k_ones = '1;

        // Right after the clear every slot holds key zero with an empty kind.
        cmd_backlog.push_back(mk_lookup('0, 8'd0, 0, 0));
        cmd_backlog.push_back(mk_lookup('0, 8'd255, -32768, 32767));
        cmd_backlog.push_back(mk_lookup(64'h1234_5678_9abc_d005, 8'd0, 0, 0));
        // Replacement within one bucket: higher priority in slot 0 pushes the
        // lower one into slot 1, equal priority overwrites slot 0.
        cmd_backlog.push_back(mk_store(k_a1, 8'd10, 32767, 100, tt_pkg::KIND_EXACT, 255));
        cmd_backlog.push_back(mk_lookup(k_a1, 8'd10, 0, 0));
        cmd_backlog.push_back(mk_lookup(k_a1, 8'd11, 0, 0));
        cmd_backlog.push_back(mk_store(k_a2, 8'd255, -32768, 50, tt_pkg::KIND_ALPHA, -1));
        cmd_backlog.push_back(mk_lookup(k_a2, 8'd0, -32768, 32767));
        cmd_backlog.push_back(mk_store(k_a3, 8'd5, 100, 100, tt_pkg::KIND_ALPHA, 7));
        cmd_backlog.push_back(mk_lookup(k_a1, 8'd0, 0, 0));
        cmd_backlog.push_back(mk_lookup(k_a3, 8'd5, 50, 80));
        cmd_backlog.push_back(mk_lookup(k_a3, 8'd0, 50, 32767));
        // An alpha bound at the top score: the window end is clamped to beta.
        cmd_backlog.push_back(mk_store(k_top, 8'd1, 32767, 1, tt_pkg::KIND_ALPHA, 128));
        cmd_backlog.push_back(mk_lookup(k_top, 8'd1, 0, 32767));
        // A beta bound at the bottom score, cut off and then narrowed.
        cmd_backlog.push_back(mk_store(k_low, 8'd0, -32768, 65535, tt_pkg::KIND_BETA, 0));
        cmd_backlog.push_back(mk_lookup(k_low, 8'd0, -32768, -32768));
        cmd_backlog.push_back(mk_lookup(k_low, 8'd0, -32768, 0));
        // A beta bound narrowed from alpha, and a window that comes out inverted.
        cmd_backlog.push_back(mk_store(k_mid, 8'd200, 10, 3, tt_pkg::KIND_BETA, 64));
        cmd_backlog.push_back(mk_lookup(k_mid, 8'd200, 100, 200));
        cmd_backlog.push_back(mk_lookup(k_mid, 8'd9, 300, 20));
        // An empty kind stored at top priority is read back as a plain hit.
        cmd_backlog.push_back(mk_store(k_hole, 8'd0, 5, 65535, tt_pkg::KIND_EMPTY, 3));
        cmd_backlog.push_back(mk_lookup(k_hole, 8'd0, 0, 0));
        cmd_backlog.push_back(mk_store(k_a1, 8'd0, -1, 0, tt_pkg::KIND_EXACT, 200));
        // Storing a key that is already present can leave it in both slots.
        cmd_backlog.push_back(mk_store(k_a3, 8'd7, 7, 0, tt_pkg::KIND_EXACT, 1));
        cmd_backlog.push_back(mk_lookup(k_a3, 8'd0, 0, 0));
        cmd_backlog.push_back(mk_store(k_ones, 8'd255, -2, 65535, tt_pkg::KIND_BETA, 255));
        cmd_backlog.push_back(mk_lookup(k_ones, 8'd255, 32767, 32767));

        // A few crowded buckets, the first and the last among them.
        pool_bucket[0] = '0;
        pool_bucket[1] = '1;
        for (int i = 2; i < 6; i++) begin
            pool_bucket[i] = tt_pkg::INDEX_BITS'($urandom);
        end
        for (int i = 0; i < POOL_SIZE; i++) begin
            key_pool[i] = {$urandom, $urandom};
            key_pool[i][tt_pkg::INDEX_BITS-1:0] = pool_bucket[i % 6];
        end
        for (int i = 0; i < RANDOM_CMDS; i++) begin
            cmd_backlog.push_back(mk_random_cmd());
        end
        n_total = cmd_backlog.size();

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        wait (n_sent == n_total);
        while (pending_answers.size() > 0) begin
            @(posedge i_clk);
        end
        repeat (10) @(posedge i_clk);

        $display("Transferred %0d commands (%0d stores, %0d lookups); %0d results checked.",
                 n_sent, n_stores, n_sent - n_stores, n_results);
        $display("Answers: miss %0d, hit %0d, exact %0d, cutoff %0d, window %0d, stored %0d.",
                 outcome_seen[tt_pkg::OUT_MISS], outcome_seen[tt_pkg::OUT_HIT],
                 outcome_seen[tt_pkg::OUT_EXACT], outcome_seen[tt_pkg::OUT_CUTOFF],
                 outcome_seen[tt_pkg::OUT_WINDOW], outcome_seen[tt_pkg::OUT_STORED]);
        if (n_errors == 0 && pending_answers.size() == 0) begin
            $display("tb_two_way_transposition_table: done, clean");
        end else begin
            $display("tb_two_way_transposition_table: done, errors");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("Timeout with %0d of %0d commands sent and %0d answers outstanding.",
                 n_sent, n_total, pending_answers.size());
        $display("tb_two_way_transposition_table: done, errors");
        $finish;
    end

endmodule

// ===== sim.f =====
src/tt_pkg.sv
src/tt_ram.sv
src/tt_front.sv
src/tt_back.sv
src/two_way_transposition_table.sv
tb/tb_two_way_transposition_table.sv
